@@ sv/efrx_pkg.sv @@
package efrx_pkg;

    // Special byte codes on the serial link.
    localparam logic [7:0] SOF_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] XON_BYTE  = 8'h11;
    localparam logic [7:0] XOFF_BYTE = 8'h13;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Frame types and the number of header bytes each one skips.
    localparam logic [7:0] TYPE_A      = 8'h80;
    localparam logic [7:0] TYPE_B      = 8'h81;
    localparam logic [7:0] TYPE_C      = 8'h90;
    localparam logic [7:0] SKIP_TYPE_A = 8'd10;
    localparam logic [7:0] SKIP_TYPE_B = 8'd4;
    localparam logic [7:0] SKIP_TYPE_C = 8'd11;

    // Payload sub-phase codes.
    localparam logic [7:0] PP_DATA   = 8'h00;
    localparam logic [7:0] PP_TYPE   = 8'hFE;
    localparam logic [7:0] PP_IGNORE = 8'hFF;

    localparam logic [7:0] CHECK_SUM = 8'hFF;

    // Number of kept data bytes.
    localparam int STORE_DEPTH = 6;
    localparam int CNT_W       = 3;
    localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_error;
    } t_beat;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

endpackage

@@ sv/efrx_parser.sv @@
module efrx_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  efrx_pkg::t_beat i_beat,
    output logic          o_valid,
    output efrx_pkg::t_rgb  o_rgb
);

    efrx_pkg::t_phase r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_pphase, n_pphase;
    logic [efrx_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]  r_store [efrx_pkg::STORE_DEPTH];
    logic        w_store_we;
    logic [7:0]  w_ub;

    // Next state for one byte beat.
    always_comb begin
        n_phase      = r_phase;
        n_esc        = r_esc;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_pphase     = r_pphase;
        n_count      = r_count;
        w_store_we   = 1'b0;
        o_valid      = 1'b0;
        w_ub         = r_esc ? (i_beat.rx_byte ^ efrx_pkg::ESC_XOR) : i_beat.rx_byte;
        if (i_valid) begin
            if (i_beat.frame_error) begin
                n_phase = efrx_pkg::PH_IDLE;
                n_esc   = 1'b0;
            end else if (i_beat.rx_byte == efrx_pkg::SOF_BYTE) begin
                n_sum   = '0;
                n_esc   = 1'b0;
                n_phase = efrx_pkg::PH_LEN_HI;
            end else if (i_beat.rx_byte == efrx_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else if (i_beat.rx_byte == efrx_pkg::XON_BYTE ||
                         i_beat.rx_byte == efrx_pkg::XOFF_BYTE) begin
                n_esc = r_esc;
            end else begin
                n_esc = 1'b0;
                case (r_phase)
                    efrx_pkg::PH_LEN_HI: begin
                        n_bytes_left = {w_ub, r_bytes_left[7:0]};
                        n_phase      = efrx_pkg::PH_LEN_LO;
                    end
                    efrx_pkg::PH_LEN_LO: begin
                        n_bytes_left = {r_bytes_left[15:8], w_ub};
                        if ({r_bytes_left[15:8], w_ub} != 16'd0) begin
                            n_pphase = efrx_pkg::PP_TYPE;
                            n_count  = '0;
                            n_phase  = efrx_pkg::PH_DATA;
                        end else begin
                            n_phase = efrx_pkg::PH_IDLE;
                        end
                    end
                    efrx_pkg::PH_DATA: begin
                        n_sum        = r_sum + w_ub;
                        n_bytes_left = r_bytes_left - 16'd1;
                        if (n_bytes_left == 16'd0) begin
                            n_phase = efrx_pkg::PH_CHECK;
                        end
                        // Frame type, header skip and data capture.
                        if (r_pphase == efrx_pkg::PP_DATA) begin
                            if (r_count < efrx_pkg::STORE_FULL) begin
                                w_store_we = 1'b1;
                                n_count    = r_count + 1'b1;
                            end
                        end else if (r_pphase == efrx_pkg::PP_TYPE) begin
                            if (w_ub == efrx_pkg::TYPE_A) begin
                                n_pphase = efrx_pkg::SKIP_TYPE_A;
                            end else if (w_ub == efrx_pkg::TYPE_B) begin
                                n_pphase = efrx_pkg::SKIP_TYPE_B;
                            end else if (w_ub == efrx_pkg::TYPE_C) begin
                                n_pphase = efrx_pkg::SKIP_TYPE_C;
                            end else begin
                                n_pphase = efrx_pkg::PP_IGNORE;
                            end
                        end else if (r_pphase != efrx_pkg::PP_IGNORE) begin
                            n_pphase = r_pphase - 8'd1;
                        end
                    end
                    efrx_pkg::PH_CHECK: begin
                        n_phase = efrx_pkg::PH_IDLE;
                        if (8'(r_sum + w_ub) == efrx_pkg::CHECK_SUM &&
                            r_pphase == efrx_pkg::PP_DATA &&
                            r_count == efrx_pkg::STORE_FULL) begin
                            o_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = efrx_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= efrx_pkg::PH_IDLE;
            r_esc        <= 1'b0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_pphase     <= '0;
            r_count      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_esc        <= n_esc;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_pphase     <= n_pphase;
            r_count      <= n_count;
        end
    end

    // Kept data bytes.
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count] <= w_ub;
        end
    end

    assign o_rgb.red   = {r_store[0], r_store[1]};
    assign o_rgb.green = {r_store[2], r_store[3]};
    assign o_rgb.blue  = {r_store[4], r_store[5]};

    // The kept-byte count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= efrx_pkg::STORE_FULL)
        else $error("kept byte count overflow");

    // A color beat is produced only from the checksum phase.
    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_phase == efrx_pkg::PH_CHECK)
        else $error("result outside checksum phase");

    // After a result the parser is idle.
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> r_phase == efrx_pkg::PH_IDLE)
        else $error("parser not idle after result");

endmodule

@@ sv/efrx_outq.sv @@
module efrx_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  efrx_pkg::t_rgb i_data,
    output logic           o_full,
    output logic           o_valid,
    output efrx_pkg::t_rgb o_data,
    input  logic           i_stall
);

    efrx_pkg::t_rgb r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    assign w_pop   = o_valid && !i_stall;
    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Nothing is written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full result queue");

    // The fill level matches the pointer distance.
    a_ptr_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with level");

endmodule

@@ sv/escaped_frame_rgb_receiver.sv @@
// Flow: a byte beat accepted on the input is held in the input register and then updates the parser;
// a color beat is registered in the result queue before it is offered on the output.
// Throughput: one byte beat per cycle while o_stall is low. The two-entry result queue
// keeps taking results while the output is stalled until it is full; then o_stall holds the input.
// Reset: synchronous active-low reset returns the parser to idle and empties all stages.
module escaped_frame_rgb_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_error,
    output logic        o_stall,
    output logic        o_valid,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    input  logic        i_stall
);

    logic            r_in_valid;
    efrx_pkg::t_beat r_in_beat;
    logic            w_q_full;
    logic            w_consume;
    logic            w_res_valid;
    efrx_pkg::t_rgb  w_res;
    efrx_pkg::t_rgb  w_out;

    // The input register holds its beat only while the result queue is full.
    assign w_consume = r_in_valid && !w_q_full;
    assign o_stall   = r_in_valid && w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_beat.rx_byte     <= i_rx_byte;
            r_in_beat.frame_error <= i_frame_error;
        end
    end

    efrx_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_consume),
        .i_beat  (r_in_beat),
        .o_valid (w_res_valid),
        .o_rgb   (w_res)
    );

    efrx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_q_full),
        .o_valid (o_valid),
        .o_data  (w_out),
        .i_stall (i_stall)
    );

    assign o_red   = w_out.red;
    assign o_green = w_out.green;
    assign o_blue  = w_out.blue;

    // A stalled input beat stays in the input register.
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_beat))
        else $error("input beat lost while stalled");

endmodule

@@ tb/escaped_frame_rgb_receiver_test.sv @@
`timescale 1ns / 1ps

// Tracks the deframer state beat by beat and holds the colors still owed.
class frame_colors;
    efrx_pkg::t_phase phase;
    bit               esc_pending;
    logic [15:0]      bytes_left;
    logic [7:0]       byte_sum;
    logic [7:0]       pay_phase;
    logic [2:0]       kept;
    logic [7:0]       store [efrx_pkg::STORE_DEPTH];
    efrx_pkg::t_rgb   due_colors [$];
    int               errors;

    function new();
        phase       = efrx_pkg::PH_IDLE;
        esc_pending = 1'b0;
        bytes_left  = '0;
        byte_sum    = '0;
        pay_phase   = efrx_pkg::PP_DATA;
        kept        = '0;
        foreach (store[i]) store[i] = '0;
        errors      = 0;
    endfunction

    // Advance the parser by one accepted byte beat.
    function void note_byte(logic [7:0] raw, logic ferr);
        logic [7:0]     b;
        logic [7:0]     total;
        efrx_pkg::t_rgb c;
        b = raw;
        if (ferr) begin
            phase       = efrx_pkg::PH_IDLE;
            esc_pending = 1'b0;
            return;
        end
        if (b == efrx_pkg::SOF_BYTE) begin
            byte_sum    = '0;
            esc_pending = 1'b0;
            phase       = efrx_pkg::PH_LEN_HI;
            return;
        end
        if (b == efrx_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
        end
        if (b == efrx_pkg::XON_BYTE || b == efrx_pkg::XOFF_BYTE) return;
        if (esc_pending) begin
            b           = b ^ efrx_pkg::ESC_XOR;
            esc_pending = 1'b0;
        end
        case (phase)
            efrx_pkg::PH_LEN_HI: begin
                bytes_left[15:8] = b;
                phase            = efrx_pkg::PH_LEN_LO;
            end
            efrx_pkg::PH_LEN_LO: begin
                bytes_left[7:0] = b;
                if (bytes_left != 0) begin
                    pay_phase = efrx_pkg::PP_TYPE;
                    kept      = '0;
                    phase     = efrx_pkg::PH_DATA;
                end else begin
                    phase = efrx_pkg::PH_IDLE;
                end
            end
            efrx_pkg::PH_DATA: begin
                byte_sum = byte_sum + b;
                // The type byte picks how many header bytes to skip before data.
                if (pay_phase == efrx_pkg::PP_DATA) begin
                    if (kept < efrx_pkg::STORE_FULL) begin
                        store[kept] = b;
                        kept        = kept + 3'd1;
                    end
                end else if (pay_phase == efrx_pkg::PP_TYPE) begin
                    case (b)
                        efrx_pkg::TYPE_A: pay_phase = efrx_pkg::SKIP_TYPE_A;
                        efrx_pkg::TYPE_B: pay_phase = efrx_pkg::SKIP_TYPE_B;
                        efrx_pkg::TYPE_C: pay_phase = efrx_pkg::SKIP_TYPE_C;
                        default:          pay_phase = efrx_pkg::PP_IGNORE;
                    endcase
                end else if (pay_phase != efrx_pkg::PP_IGNORE) begin
                    pay_phase = pay_phase - 8'd1;
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0) phase = efrx_pkg::PH_CHECK;
            end
            efrx_pkg::PH_CHECK: begin
                phase       = efrx_pkg::PH_IDLE;
                esc_pending = 1'b0;
                total       = byte_sum + b;
                if (total == efrx_pkg::CHECK_SUM && pay_phase == efrx_pkg::PP_DATA &&
                    kept == efrx_pkg::STORE_FULL) begin
                    c.red   = {store[0], store[1]};
                    c.green = {store[2], store[3]};
                    c.blue  = {store[4], store[5]};
                    due_colors.push_back(c);
                end
            end
            default: phase = efrx_pkg::PH_IDLE;
        endcase
    endfunction

    // Compare one accepted color beat with the oldest color owed.
    function void check_color(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
        efrx_pkg::t_rgb want;
        if (due_colors.size() == 0) begin
            $error("color beat with no frame owed: red %h green %h blue %h", red, green, blue);
            errors++;
            return;
        end
        want = due_colors.pop_front();
        if (red !== want.red) begin
            $error("red: expected %h, got %h", want.red, red);
            errors++;
        end
        if (green !== want.green) begin
            $error("green: expected %h, got %h", want.green, green);
            errors++;
        end
        if (blue !== want.blue) begin
            $error("blue: expected %h, got %h", want.blue, blue);
            errors++;
        end
    endfunction
endclass

module escaped_frame_rgb_receiver_test;

    localparam int LATENCY     = 2;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TOTAL_BEATS = 750;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        i_frame_error = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_red;
    logic [15:0] o_green;
    logic [15:0] o_blue;

    frame_colors colors;
    logic [7:0]  frame_body [$];
    int          burst_left = 0;
    int          beats_sent = 0;
    int          stall_mode = 0;
    int          stall_span = 0;
    int          stall_tick = 0;

    escaped_frame_rgb_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_rx_byte     (i_rx_byte),
        .i_frame_error (i_frame_error),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .i_stall       (i_stall)
    );

    always #4 i_clk = ~i_clk;

    // Receiver stall: switches among several patterns, including none at all.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_span = $urandom_range(20, 200);
        end else begin
            stall_span--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= (stall_tick % 8) >= 5;
            3:       i_stall <= $urandom_range(0, 1);
            default: i_stall <= (stall_tick % 32) < 12;
        endcase
    end

    // Every accepted byte beat feeds the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) colors.note_byte(i_rx_byte, i_frame_error);
    end

    // Every accepted color beat is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) colors.check_color(o_red, o_green, o_blue);
    end

    // Watchdog: too many cycles in a row with no beat moving on either side.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic bit is_reserved(logic [7:0] b);
        return b == efrx_pkg::SOF_BYTE || b == efrx_pkg::ESC_BYTE ||
               b == efrx_pkg::XON_BYTE || b == efrx_pkg::XOFF_BYTE;
    endfunction

    // Send one byte beat; the sender runs in bursts with random gaps between them.
    task automatic put_byte(logic [7:0] b, logic ferr);
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_error <= ferr;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Send one logical byte, escaping reserved codes and sometimes others,
    // with flow-control bytes sprinkled in at random.
    task automatic send_coded(logic [7:0] b, int esc_pct, int xon_pct);
        bit flip;
        if ($urandom_range(0, 99) < xon_pct)
            put_byte($urandom_range(0, 1) ? efrx_pkg::XON_BYTE : efrx_pkg::XOFF_BYTE, 1'b0);
        flip = !is_reserved(b ^ efrx_pkg::ESC_XOR) && ($urandom_range(0, 99) < esc_pct);
        if (is_reserved(b) || flip) begin
            put_byte(efrx_pkg::ESC_BYTE, 1'b0);
            if ($urandom_range(0, 99) < xon_pct)
                put_byte($urandom_range(0, 1) ? efrx_pkg::XON_BYTE : efrx_pkg::XOFF_BYTE,
                         1'b0);
            put_byte(b ^ efrx_pkg::ESC_XOR, 1'b0);
        end else begin
            put_byte(b, 1'b0);
        end
    endtask

    // Type byte, header bytes to skip, then random data bytes.
    task automatic fill_body(logic [7:0] ftype, int hdr_n, int data_n);
        frame_body.delete();
        frame_body.push_back(ftype);
        repeat (hdr_n) frame_body.push_back(8'($urandom));
        repeat (data_n) frame_body.push_back(8'($urandom));
    endtask

    // Send a whole frame around frame_body; the length may be skewed and the
    // checksum spoiled on purpose.
    task automatic send_frame(int len_delta, bit good_sum, int esc_pct, int xon_pct);
        logic [15:0] len;
        logic [7:0]  cks;
        int          n;
        n = frame_body.size() + len_delta;
        if (n < 0) n = 0;
        len = n[15:0];
        cks = efrx_pkg::CHECK_SUM;
        foreach (frame_body[i]) cks = cks - frame_body[i];
        if (!good_sum) cks = cks ^ 8'($urandom_range(1, 255));
        put_byte(efrx_pkg::SOF_BYTE, 1'b0);
        send_coded(len[15:8], esc_pct, xon_pct);
        send_coded(len[7:0], esc_pct, xon_pct);
        foreach (frame_body[i]) send_coded(frame_body[i], esc_pct, xon_pct);
        send_coded(cks, esc_pct, xon_pct);
    endtask

    // Hold the sender off until every owed color has come out.
    task automatic drain_colors();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (colors.due_colors.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        int next_drain;
        logic [7:0] ftype;
        int hdr_n;

        colors = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Shortest header, data at the byte extremes.
        frame_body = '{efrx_pkg::TYPE_B, 8'h00, 8'h01, 8'h02, 8'h03,
                       8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01};
        send_frame(0, 1'b1, 0, 0);
        // Data holds the reserved codes, which go out escaped, then ESC_XOR and 8'h5E, which go out plain.
        fill_body(efrx_pkg::TYPE_A, efrx_pkg::SKIP_TYPE_A, 0);
        frame_body.push_back(efrx_pkg::SOF_BYTE);
        frame_body.push_back(efrx_pkg::ESC_BYTE);
        frame_body.push_back(efrx_pkg::XON_BYTE);
        frame_body.push_back(efrx_pkg::XOFF_BYTE);
        frame_body.push_back(efrx_pkg::ESC_XOR);
        frame_body.push_back(8'h5E);
        send_frame(0, 1'b1, 0, 0);
        // Longest header with heavy escaping and flow control.
        fill_body(efrx_pkg::TYPE_C, efrx_pkg::SKIP_TYPE_C, 6);
        send_frame(0, 1'b1, 60, 40);
        // Unknown type is ignored.
        fill_body(8'h00, efrx_pkg::SKIP_TYPE_A, 6);
        send_frame(0, 1'b1, 0, 0);
        // Zero length goes back to idle; the trailing byte is ignored.
        frame_body.delete();
        send_frame(0, 1'b1, 0, 0);
        // Bad checksum.
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(0, 1'b0, 0, 0);
        // Five data bytes give no color; seven give one made from the first six.
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 5);
        send_frame(0, 1'b1, 0, 0);
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 7);
        send_frame(0, 1'b1, 0, 0);
        // Framing error mid-frame; a flagged start byte is discarded too.
        put_byte(efrx_pkg::SOF_BYTE, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h0B, 1'b0);
        put_byte(efrx_pkg::TYPE_B, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(efrx_pkg::SOF_BYTE, 1'b1);
        put_byte(8'h00, 1'b0);
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(0, 1'b1, 0, 0);
        // Start byte inside a frame with a huge length.
        put_byte(efrx_pkg::SOF_BYTE, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(efrx_pkg::TYPE_B, 1'b0);
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(0, 1'b1, 100, 0);
        // Idle escapes: double escape, flow control in between, then an
        // ordinary byte that uses the escape up.
        put_byte(efrx_pkg::ESC_BYTE, 1'b0);
        put_byte(efrx_pkg::ESC_BYTE, 1'b0);
        put_byte(efrx_pkg::XON_BYTE, 1'b0);
        put_byte(8'h5E, 1'b0);
        // Escape left pending into a start byte, and across a framing error.
        put_byte(efrx_pkg::ESC_BYTE, 1'b0);
        fill_body(efrx_pkg::TYPE_A, efrx_pkg::SKIP_TYPE_A, 6);
        send_frame(0, 1'b1, 0, 0);
        put_byte(efrx_pkg::ESC_BYTE, 1'b0);
        put_byte(8'h00, 1'b1);
        fill_body(efrx_pkg::TYPE_C, efrx_pkg::SKIP_TYPE_C, 6);
        send_frame(0, 1'b1, 0, 0);
        // Length too long, then too short, then right with some escaping and flow control.
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(2, 1'b1, 0, 0);
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(-1, 1'b1, 0, 0);
        fill_body(efrx_pkg::TYPE_B, efrx_pkg::SKIP_TYPE_B, 6);
        send_frame(0, 1'b1, 20, 10);
        drain_colors();

        // Random part: mostly well-formed frames, some noise and broken ones.
        next_drain = beats_sent + $urandom_range(150, 300);
        while (beats_sent < TOTAL_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0: begin
                        ftype = efrx_pkg::TYPE_A;
                        hdr_n = efrx_pkg::SKIP_TYPE_A;
                    end
                    1: begin
                        ftype = efrx_pkg::TYPE_C;
                        hdr_n = efrx_pkg::SKIP_TYPE_C;
                    end
                    default: begin
                        ftype = efrx_pkg::TYPE_B;
                        hdr_n = efrx_pkg::SKIP_TYPE_B;
                    end
                endcase
                fill_body(ftype, hdr_n, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : 6);
                send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) - 2 : 0,
                           $urandom_range(0, 9) != 0, $urandom_range(0, 15),
                           $urandom_range(0, 8));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) put_byte(8'($urandom), 1'b0);
            end else if (pick < 88) begin
                // Truncated frame ended by a framing error.
                put_byte(efrx_pkg::SOF_BYTE, 1'b0);
                repeat ($urandom_range(0, 12)) send_coded(8'($urandom), 10, 5);
                put_byte(8'($urandom), 1'b1);
            end else begin
                // Unknown type or zero length.
                if ($urandom_range(0, 1)) begin
                    do ftype = 8'($urandom);
                    while (ftype == efrx_pkg::TYPE_A || ftype == efrx_pkg::TYPE_B ||
                           ftype == efrx_pkg::TYPE_C);
                    fill_body(ftype, $urandom_range(0, 11), 6);
                end else begin
                    frame_body.delete();
                end
                send_frame(0, 1'b1, 10, 5);
            end
            if (beats_sent >= next_drain) begin
                drain_colors();
                next_drain = beats_sent + $urandom_range(150, 300);
            end
        end

        drain_colors();
        if (colors.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ escaped_frame_rgb_receiver.f @@
sv/efrx_pkg.sv
sv/efrx_parser.sv
sv/efrx_outq.sv
sv/escaped_frame_rgb_receiver.sv
tb/escaped_frame_rgb_receiver_test.sv
